>>> hdl/ihb_pkg.sv
// ihb_pkg: shared types, constants and register indexes for the ipv4 header builder
// used by ihb_cfg, ihb_calc and ipv4_header_build_route_unit; no dependencies
`default_nettype none

package ihb_pkg;

    // header constants
    localparam logic [7:0]  VER_IHL   = 8'h45;
    localparam logic [15:0] HDR_BYTES = 16'd20;

    // configuration register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam logic [1:0]  CFG_LOCAL_ADDR   = 2'd0;
    localparam logic [1:0]  CFG_SUBNET_MASK  = 2'd1;
    localparam logic [1:0]  CFG_GATEWAY_ADDR = 2'd2;
    localparam logic [1:0]  CFG_PACKET_TTL   = 2'd3;

    // reset values
    localparam logic [31:0] RST_LOCAL_ADDR   = 32'h0000_0000;
    localparam logic [31:0] RST_SUBNET_MASK  = 32'hFFFF_FF00;
    localparam logic [31:0] RST_GATEWAY_ADDR = 32'h0000_0000;
    localparam logic [7:0]  RST_PACKET_TTL   = 8'd64;

    // request type codes
    localparam logic REQ_SEND  = 1'b0;
    localparam logic REQ_REPLY = 1'b1;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [31:0] subnet_mask;
        logic [31:0] gateway_addr;
        logic [7:0]  packet_ttl;
    } t_cfg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] dest_addr;
        logic [15:0] payload_len;
        logic [7:0]  protocol;
        logic [7:0]  tos;
    } t_req;

    typedef struct packed {
        logic [15:0] ip_length;
        logic [7:0]  header_tos;
        logic [7:0]  header_ttl;
        logic [31:0] header_dest;
        logic [15:0] header_checksum;
        logic [31:0] next_hop_addr;
        logic        via_gateway;
    } t_hdr;

endpackage

`default_nettype wire

>>> hdl/ihb_cfg.sv
// ihb_cfg: configuration register file (local address, mask, gateway, ttl)
// depends on ihb_pkg
`default_nettype none

module ihb_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr_en,
    input  wire logic [ihb_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [31:0]                 i_wr_data,
    output ihb_pkg::t_cfg                    o_cfg
);

    ihb_pkg::t_cfg r_cfg;
    ihb_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                ihb_pkg::CFG_LOCAL_ADDR:   n_cfg.local_addr   = i_wr_data;
                ihb_pkg::CFG_SUBNET_MASK:  n_cfg.subnet_mask  = i_wr_data;
                ihb_pkg::CFG_GATEWAY_ADDR: n_cfg.gateway_addr = i_wr_data;
                ihb_pkg::CFG_PACKET_TTL:   n_cfg.packet_ttl   = i_wr_data[7:0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_addr   <= ihb_pkg::RST_LOCAL_ADDR;
            r_cfg.subnet_mask  <= ihb_pkg::RST_SUBNET_MASK;
            r_cfg.gateway_addr <= ihb_pkg::RST_GATEWAY_ADDR;
            r_cfg.packet_ttl   <= ihb_pkg::RST_PACKET_TTL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hdl/ihb_calc.sv
// ihb_calc: header field build, route decision and ones-complement checksum
// purely combinational; depends on ihb_pkg
`default_nettype none

module ihb_calc (
    input  ihb_pkg::t_cfg i_cfg,
    input  ihb_pkg::t_req i_req,
    output ihb_pkg::t_hdr o_hdr
);

    logic        is_reply;
    logic [15:0] tlen;
    logic [7:0]  tos_out;
    logic        on_subnet;
    logic [18:0] sum_raw;
    logic [16:0] sum_fold1;
    logic [15:0] sum_fold2;

    assign is_reply  = (i_req.req_type == ihb_pkg::REQ_REPLY);
    assign tlen      = i_req.payload_len + ihb_pkg::HDR_BYTES;   // wraps mod 2^16
    assign tos_out   = is_reply ? i_req.tos : 8'd0;
    assign on_subnet = (((i_req.dest_addr ^ i_cfg.local_addr) & i_cfg.subnet_mask) == 32'd0);

    // seven nonzero header words, checksum and fragment words taken as zero
    assign sum_raw = 19'({ihb_pkg::VER_IHL, tos_out})
                   + 19'(tlen)
                   + 19'({i_cfg.packet_ttl, i_req.protocol})
                   + 19'(i_cfg.local_addr[31:16])
                   + 19'(i_cfg.local_addr[15:0])
                   + 19'(i_req.dest_addr[31:16])
                   + 19'(i_req.dest_addr[15:0]);

    // two end-around folds are enough for a 19-bit sum
    assign sum_fold1 = 17'(sum_raw[15:0]) + 17'(sum_raw[18:16]);
    assign sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);

    always_comb begin
        o_hdr.ip_length       = tlen;
        o_hdr.header_tos      = tos_out;
        o_hdr.header_ttl      = i_cfg.packet_ttl;
        o_hdr.header_dest     = i_req.dest_addr;
        o_hdr.header_checksum = ~sum_fold2;
        if (is_reply || on_subnet) begin
            o_hdr.next_hop_addr = i_req.dest_addr;
            o_hdr.via_gateway   = 1'b0;
        end else begin
            o_hdr.next_hop_addr = i_cfg.gateway_addr;
            o_hdr.via_gateway   = 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ipv4_header_build_route_unit.sv
// ipv4_header_build_route_unit: top level of the ipv4 header builder with next-hop routing
// depends on ihb_pkg, ihb_cfg and ihb_calc
`default_nettype none

// One request in, one header result out, one transaction per clock sustained
// while the downstream side does not stall. A request is captured in the
// input register, the header fields, route decision and checksum are formed
// by a single combinational pass (ihb_calc), and the result lands in the output
// register. A register loads when empty or its content moves on, so a new
// request is taken while the previous result waits at the output; o_in_stall
// rises only when both stages hold data and the downstream side is stalling.
// Configuration writes are taken every cycle (o_cfg_ready is tied high) and
// must only happen while no request is in flight. A send (req_type 0) gets tos
// 0 and goes to the gateway when the destination is off the local subnet; a
// reply keeps the received tos and always resolves the destination itself.
module ipv4_header_build_route_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output wire logic                          o_cfg_ready,
    input  wire logic [ihb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data,
    // request channel
    input  wire logic                          i_in_valid,
    output wire logic                          o_in_stall,
    input  wire logic                          i_req_type,
    input  wire logic [31:0]                   i_dest_addr,
    input  wire logic [15:0]                   i_payload_len,
    input  wire logic [7:0]                    i_protocol,
    input  wire logic [7:0]                    i_tos,
    // result channel
    output wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output wire logic [15:0]                   o_ip_length,
    output wire logic [7:0]                    o_header_tos,
    output wire logic [7:0]                    o_header_ttl,
    output wire logic [31:0]                   o_header_dest,
    output wire logic [15:0]                   o_header_checksum,
    output wire logic [31:0]                   o_next_hop_addr,
    output wire logic                          o_via_gateway
);

    ihb_pkg::t_cfg cfg;
    ihb_pkg::t_hdr calc_hdr;

    // pipeline registers
    logic          r_s1_valid;
    ihb_pkg::t_req r_s1_req;
    logic          r_s2_valid;
    ihb_pkg::t_hdr r_s2_hdr;

    logic s2_load_en;   // output stage can take a new value
    logic s1_load_en;   // input stage can take a new value
    logic in_xact;      // request transaction this cycle

    // config is always writable
    assign o_cfg_ready = 1'b1;

    ihb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // stage advance: a stage loads when it is empty or its content moves on
    assign s2_load_en = !r_s2_valid || !i_out_stall;
    assign s1_load_en = !r_s1_valid || s2_load_en;
    assign o_in_stall = !s1_load_en;
    assign in_xact    = i_in_valid && s1_load_en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_s1_req.req_type    <= i_req_type;
            r_s1_req.dest_addr   <= i_dest_addr;
            r_s1_req.payload_len <= i_payload_len;
            r_s1_req.protocol    <= i_protocol;
            r_s1_req.tos         <= i_tos;
        end
    end

    // header build, route and checksum in one pass
    ihb_calc u_calc (
        .i_cfg (cfg),
        .i_req (r_s1_req),
        .o_hdr (calc_hdr)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load_en && r_s1_valid) begin
            r_s2_hdr <= calc_hdr;
        end
    end

    assign o_out_valid       = r_s2_valid;
    assign o_ip_length       = r_s2_hdr.ip_length;
    assign o_header_tos      = r_s2_hdr.header_tos;
    assign o_header_ttl      = r_s2_hdr.header_ttl;
    assign o_header_dest     = r_s2_hdr.header_dest;
    assign o_header_checksum = r_s2_hdr.header_checksum;
    assign o_next_hop_addr   = r_s2_hdr.next_hop_addr;
    assign o_via_gateway     = r_s2_hdr.via_gateway;

`ifndef SYNTHESIS
    // only a send is routed via the gateway, and sends carry tos zero
    a_gw_tos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_hdr.via_gateway) |-> (r_s2_hdr.header_tos == 8'd0))
        else $error("gateway-routed header with nonzero tos");

    // direct delivery resolves the header destination itself
    a_direct_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_hdr.via_gateway)
            |-> (r_s2_hdr.next_hop_addr == r_s2_hdr.header_dest))
        else $error("direct next hop differs from header destination");

    // the input side never stalls while the input register is empty
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid))
        else $error("request stalled with a free pipeline stage");
`endif

endmodule

`default_nettype wire

>>> tb/ipv4_header_build_route_unit_tb.sv
// ipv4_header_build_route_unit_tb: self-checking testbench for the ipv4 header builder
// drives requests and register writes, predicts every header and compares it field by field
// depends on ihb_pkg and ipv4_header_build_route_unit
module ipv4_header_build_route_unit_tb;
    import ihb_pkg::*;

    // run shape
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_CYCLES     = 48;     // long downstream hold-off
    localparam int LATENCY_CYCLES  = 4;      // two-stage pipe plus margin
    localparam int WATCHDOG_LIMIT  = 5000;   // cycles with no transaction at all

    // one directed stimulus row; typed rows carry a hand-written header
    typedef struct {
        t_req req;
        bit   typed;
        t_hdr hdr;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_req_type;
    logic [31:0]          i_dest_addr;
    logic [15:0]          i_payload_len;
    logic [7:0]           i_protocol;
    logic [7:0]           i_tos;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [15:0]          o_ip_length;
    logic [7:0]           o_header_tos;
    logic [7:0]           o_header_ttl;
    logic [31:0]          o_header_dest;
    logic [15:0]          o_header_checksum;
    logic [31:0]          o_next_hop_addr;
    logic                 o_via_gateway;

    // register contents as the block holds them, updated on each write transaction
    t_cfg cfg_now;
    // headers owed by the block, oldest first
    t_hdr hdr_due_q[$];

    int fail_count  = 0;
    int hdr_seen    = 0;
    int idle_cycles = 0;

    // pacing controls shared between stimulus and the downstream stall process
    bit calm         = 1'b0;   // no idling on either side
    bit rush         = 1'b0;   // sender offers back to back
    bit hold_off_req = 1'b0;   // ask downstream for one long hold-off

    ipv4_header_build_route_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_dest_addr       (i_dest_addr),
        .i_payload_len     (i_payload_len),
        .i_protocol        (i_protocol),
        .i_tos             (i_tos),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_ip_length       (o_ip_length),
        .o_header_tos      (o_header_tos),
        .o_header_ttl      (o_header_ttl),
        .o_header_dest     (o_header_dest),
        .o_header_checksum (o_header_checksum),
        .o_next_hop_addr   (o_next_hop_addr),
        .o_via_gateway     (o_via_gateway)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected header for one request under the given register contents
    function automatic t_hdr form_header(input t_req r, input t_cfg c);
        t_hdr        h;
        logic [31:0] sum;
        h.ip_length   = r.payload_len + HDR_BYTES;   // wraps modulo 2^16 on oversize payloads
        h.header_tos  = (r.req_type == REQ_REPLY) ? r.tos : 8'h00;
        h.header_ttl  = c.packet_ttl;
        h.header_dest = r.dest_addr;
        // replies never route; sends go direct only when on the local subnet
        if (r.req_type == REQ_REPLY ||
            ((r.dest_addr ^ c.local_addr) & c.subnet_mask) == 32'h0) begin
            h.next_hop_addr = r.dest_addr;
            h.via_gateway   = 1'b0;
        end else begin
            h.next_hop_addr = c.gateway_addr;
            h.via_gateway   = 1'b1;
        end
        // seven nonzero header words; checksum word and fragment words are zero
        sum = {16'h0, VER_IHL, h.header_tos} + {16'h0, h.ip_length}
            + {16'h0, c.packet_ttl, r.protocol}
            + {16'h0, c.local_addr[31:16]} + {16'h0, c.local_addr[15:0]}
            + {16'h0, r.dest_addr[31:16]} + {16'h0, r.dest_addr[15:0]};
        // end-around carry
        while (sum[31:16] != 16'h0)
            sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
        h.header_checksum = ~sum[15:0];
        return h;
    endfunction

    task automatic log_failure(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_failure($sformatf("header %0d %s got 0x%0h want 0x%0h",
                                  hdr_seen, name, got, want));
    endtask

    // one register write transaction; the copy follows at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LOCAL_ADDR:   cfg_now.local_addr   = data;
            CFG_SUBNET_MASK:  cfg_now.subnet_mask  = data;
            CFG_GATEWAY_ADDR: cfg_now.gateway_addr = data;
            CFG_PACKET_TTL:   cfg_now.packet_ttl   = data[7:0];
            default: ;
        endcase
    endtask

    task automatic write_cfg(input t_cfg c);
        write_reg(CFG_LOCAL_ADDR,   c.local_addr);
        write_reg(CFG_SUBNET_MASK,  c.subnet_mask);
        write_reg(CFG_GATEWAY_ADDR, c.gateway_addr);
        write_reg(CFG_PACKET_TTL,   {24'h0, c.packet_ttl});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, let every owed header come out, then wait out the LATENCY_CYCLES margin
    task automatic settle_pipeline();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (hdr_due_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY_CYCLES) @(negedge i_clk);
    endtask

    // offer one request, possibly after a short idle burst, and book its header
    task automatic offer_req(input t_req r, input bit typed, input t_hdr typed_hdr);
        int gap;
        if (!calm && !rush && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_req_type    <= r.req_type;
        i_dest_addr   <= r.dest_addr;
        i_payload_len <= r.payload_len;
        i_protocol    <= r.protocol;
        i_tos         <= r.tos;
        do @(posedge i_clk); while (o_in_stall);
        hdr_due_q.push_back(typed ? typed_hdr : form_header(r, cfg_now));
    endtask

    // downstream stall: alternating runs, one long hold-off on request, none when calm
    initial begin
        int run_left;
        bit run_high;
        run_left    = 0;
        run_high    = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                run_high     = 1'b1;
                run_left     = HOLD_CYCLES;
            end else if (run_left <= 0) begin
                if (calm) begin
                    run_high = 1'b0;
                    run_left = 1;
                end else begin
                    run_high = ($urandom_range(0, 2) == 0);
                    run_left = run_high ? $urandom_range(1, 6) : $urandom_range(1, 12);
                end
            end
            i_out_stall <= run_high;
            run_left--;
        end
    end

    // result checker: every accepted header against the oldest one owed
    always @(posedge i_clk) begin
        t_hdr got;
        t_hdr want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_ip_length, o_header_tos, o_header_ttl, o_header_dest,
                    o_header_checksum, o_next_hop_addr, o_via_gateway};
            if (hdr_due_q.size() == 0) begin
                log_failure($sformatf("header with none owed, dest 0x%0h", got.header_dest));
            end else begin
                want = hdr_due_q.pop_front();
                check_field("ip_length", 32'(got.ip_length), 32'(want.ip_length));
                check_field("header_tos", 32'(got.header_tos), 32'(want.header_tos));
                check_field("header_ttl", 32'(got.header_ttl), 32'(want.header_ttl));
                check_field("header_dest", got.header_dest, want.header_dest);
                check_field("header_checksum", 32'(got.header_checksum),
                            32'(want.header_checksum));
                check_field("next_hop_addr", got.next_hop_addr, want.next_hop_addr);
                check_field("via_gateway", 32'(got.via_gateway), 32'(want.via_gateway));
            end
            hdr_seen++;
        end
    end

    // watchdog: ends the run after too long without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // main stimulus
    initial begin
        t_req        r;
        t_cfg        phase_cfg[N_PHASES];
        t_dir_row    dir_tab[$];
        logic [31:0] host_mask;

        // every input known from time zero, reset held low
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_LOCAL_ADDR;
        i_cfg_data    = 32'h0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_SEND;
        i_dest_addr   = 32'h0;
        i_payload_len = 16'h0;
        i_protocol    = 8'h0;
        i_tos         = 8'h0;
        cfg_now = '{RST_LOCAL_ADDR, RST_SUBNET_MASK, RST_GATEWAY_ADDR, RST_PACKET_TTL};

        // directed rows, run under the reset register values:
        // local 0, mask ffffff00, gateway 0, ttl 64
        // all-zero request: 4500 + 0014 + 4000 folds to 8514, checksum 7aeb
        dir_tab.push_back('{'{REQ_REPLY, 32'h0, 16'd0, 8'h00, 8'h00}, 1'b1,
                            '{16'd20, 8'h00, 8'd64, 32'h0, 16'h7AEB, 32'h0, 1'b0}});
        dir_tab.push_back('{'{REQ_SEND, 32'h0, 16'd0, 8'h00, 8'h00}, 1'b1,
                            '{16'd20, 8'h00, 8'd64, 32'h0, 16'h7AEB, 32'h0, 1'b0}});
        // length overflow: ffff + 20 wraps to 19
        dir_tab.push_back('{'{REQ_SEND, 32'h0, 16'hFFFF, 8'h00, 8'h00}, 1'b1,
                            '{16'd19, 8'h00, 8'd64, 32'h0, 16'h7AEC, 32'h0, 1'b0}});
        // all-ones reply keeps tos and resolves the destination itself
        dir_tab.push_back('{'{REQ_REPLY, 32'hFFFF_FFFF, 16'd65515, 8'hFF, 8'hFF}, 1'b1,
                            '{16'hFFFF, 8'hFF, 8'd64, 32'hFFFF_FFFF, 16'h7901,
                              32'hFFFF_FFFF, 1'b0}});
        // all-ones send is off subnet: tos forced to zero, next hop is the gateway
        dir_tab.push_back('{'{REQ_SEND, 32'hFFFF_FFFF, 16'd65515, 8'hFF, 8'hFF}, 1'b1,
                            '{16'hFFFF, 8'h00, 8'd64, 32'hFFFF_FFFF, 16'h7A00,
                              32'h0, 1'b1}});
        // subnet edges, tos on sends, reply routing, wrap, bit patterns
        dir_tab.push_back('{'{REQ_SEND,  32'h0000_00FF, 16'd100,   8'h06, 8'h10}, 1'b0, '0});
        dir_tab.push_back('{'{REQ_SEND,  32'h0000_0100, 16'd1500,  8'h11, 8'h00}, 1'b0, '0});
        dir_tab.push_back('{'{REQ_REPLY, 32'hC0A8_0105, 16'd64,    8'h01, 8'hB8}, 1'b0, '0});
        dir_tab.push_back('{'{REQ_SEND,  32'h8000_0000, 16'd65516, 8'h11, 8'h00}, 1'b0, '0});
        dir_tab.push_back('{'{REQ_REPLY, 32'h7FFF_FFFF, 16'hFFFF,  8'hFF, 8'h01}, 1'b0, '0});
        dir_tab.push_back('{'{REQ_SEND,  32'h0000_0001, 16'h5555,  8'hAA, 8'h55}, 1'b0, '0});
        dir_tab.push_back('{'{REQ_REPLY, 32'h55AA_55AA, 16'hAAAA,  8'h55, 8'hAA}, 1'b0, '0});
        dir_tab.push_back('{'{REQ_SEND,  32'hFFFF_FF00, 16'd1,     8'h80, 8'h80}, 1'b0, '0});
        dir_tab.push_back('{'{REQ_SEND,  32'h0000_00FE, 16'd65515, 8'h01, 8'hFF}, 1'b0, '0});

        // register settings per random phase, extremes among them
        phase_cfg[0] = '{32'hC0A8_0064, 32'hFFFF_FF00, 32'hC0A8_0001, 8'd64};
        phase_cfg[1] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd0};
        phase_cfg[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255};
        phase_cfg[3] = '{32'h0A00_0005, 32'hFF00_0000, 32'h0A00_00FE, 8'd128};
        phase_cfg[4] = '{$urandom, $urandom, $urandom, 8'($urandom)};
        phase_cfg[5] = '{32'hAC10_0A0A, 32'hFFFF_FFFC, 32'hAC10_0A09, 8'd1};
        phase_cfg[6] = '{$urandom, 32'hFFFF_FFFF << $urandom_range(0, 32), $urandom,
                         8'($urandom)};
        phase_cfg[7] = '{$urandom, 32'hFFFF_0000, $urandom, 8'($urandom)};

        // synchronous reset held low, then released at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k])
            offer_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].hdr);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // last phase runs with no idling anywhere
            if (ph == N_PHASES - 1)
                calm = 1'b1;
            // registers change only with the pipe empty
            settle_pipeline();
            write_cfg(phase_cfg[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // back-pressure: long downstream hold while offers keep coming
                if (ph == 2 && n == 20) begin
                    hold_off_req = 1'b1;
                    rush         = 1'b1;
                end
                if (ph == 2 && n == 70)
                    rush = 1'b0;
                // sender pause until every owed header is out
                if (ph == 3 && n == 60)
                    settle_pipeline();

                r.req_type = 1'($urandom_range(0, 1));
                // half the destinations land on the local subnet
                host_mask = ~cfg_now.subnet_mask;
                if ($urandom_range(0, 1) == 0)
                    r.dest_addr = (cfg_now.local_addr & cfg_now.subnet_mask) |
                                  ($urandom & host_mask);
                else
                    r.dest_addr = $urandom;
                case ($urandom_range(0, 7))
                    0:       r.payload_len = 16'd0;
                    1:       r.payload_len = 16'hFFFF;
                    2:       r.payload_len = 16'($urandom_range(65500, 65535));
                    default: r.payload_len = 16'($urandom);
                endcase
                r.protocol = 8'($urandom);
                r.tos      = 8'($urandom);
                offer_req(r, 1'b0, '0);
            end
        end

        settle_pipeline();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
